### sv/bbd_pkg.sv
// Shared types and constants for the 2x2 BGRA box downsampler.
package bbd_pkg;

	// Fixed pixel and sum geometry.
	localparam int PIXEL_W   = 32;
	localparam int CHAN_W    = 8;
	localparam int NUM_CHAN  = 4;
	localparam int SUM_W     = 9;
	localparam int SUMS_W    = SUM_W * NUM_CHAN;
	localparam int CFG_W     = 12;

	// Depth of the command queue and of the result queue.
	localparam int QUEUE_DEPTH = 4;

	// Command from the front to the back, less the column index.
	typedef struct packed {
		logic              odd_row;
		logic              end_of_row;
		logic [SUMS_W-1:0] sums;
	} cmd_t;

	// One finished result beat.
	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               end_of_row;
	} res_t;

	// Per-channel sums of two pixels, packed as four 9-bit fields.
	function automatic logic [SUMS_W-1:0] pair_sums(input logic [PIXEL_W-1:0] p0,
		input logic [PIXEL_W-1:0] p1);
		logic [SUMS_W-1:0] packed_sums;
		packed_sums = '0;
		for (int c = 0; c < NUM_CHAN; c++) begin
			packed_sums[c*SUM_W +: SUM_W] = {1'b0, p0[c*CHAN_W +: CHAN_W]}
				+ {1'b0, p1[c*CHAN_W +: CHAN_W]};
		end
		return packed_sums;
	endfunction

endpackage

### sv/bbd_fifo.sv
// Small register-based queue with fill level, used for the command queue and the result queue.
module bbd_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [W-1:0]               wdata,
	input  logic                       pop,
	output logic [W-1:0]               rdata,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] level
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);

	logic [W-1:0]  store_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [LW-1:0] level_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (level_q == LW'(DEPTH));
	assign empty   = (level_q == '0);
	assign level   = level_q;
	assign rdata   = store_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + LW'(1);
			end else if (do_pop && !do_push) begin
				level_q <= level_q - LW'(1);
			end
		end
	end

endmodule

### sv/bbd_front.sv
// Front end: takes pixels, tracks row position, forms pair sums and issues commands.
module bbd_front #(
	parameter int MAX_PAIRS = 2048,
	parameter int CW        = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [bbd_pkg::CFG_W-1:0]   cfg_wr_data,
	input  logic                        push,
	input  logic [bbd_pkg::PIXEL_W-1:0] pixel_in,
	input  logic                        start_of_frame,
	input  logic                        cmd_full,
	output logic                        full,
	output logic                        cmd_push,
	output bbd_pkg::cmd_t               cmd,
	output logic [CW-1:0]               cmd_col
);
	import bbd_pkg::*;

	// Wide enough for the clamped width and for the configured value.
	localparam int WW = (CW + 1 > CFG_W + 1) ? CW + 1 : CFG_W + 1;

	logic [PIXEL_W-1:0] held_q;
	logic [CW-1:0]      col_q;
	logic               second_q;
	logic               odd_q;
	logic [WW-1:0]      width_q;

	logic               accept;
	logic               sec_eff;
	logic [CW-1:0]      col_eff;
	logic               odd_eff;
	logic               last;
	logic [WW-1:0]      cfg_ext;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	// A start-of-frame beat restarts the position before it is used.
	assign sec_eff = start_of_frame ? 1'b0 : second_q;
	assign col_eff = start_of_frame ? '0 : col_q;
	assign odd_eff = start_of_frame ? 1'b0 : odd_q;
	assign last    = (WW'(col_eff) + WW'(1)) >= width_q;
	assign cfg_ext = WW'(cfg_wr_data);

	// Command for the back end, issued on the second pixel of a pair.
	assign cmd_push       = accept && sec_eff;
	assign cmd.odd_row    = odd_eff;
	assign cmd.end_of_row = last;
	assign cmd.sums       = pair_sums(held_q, pixel_in);
	assign cmd_col        = col_eff;

	// Held first pixel of a pair.
	always_ff @(posedge clk) begin
		if (accept && !sec_eff) begin
			held_q <= pixel_in;
		end
	end

	// Position tracking and width register, clamped to the legal range when written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			second_q <= 1'b0;
			odd_q    <= 1'b0;
			width_q  <= WW'(1);
		end else begin
			if (cfg_wr_en) begin
				if (cfg_ext == '0) begin
					width_q <= WW'(1);
				end else if (cfg_ext > WW'(MAX_PAIRS)) begin
					width_q <= WW'(MAX_PAIRS);
				end else begin
					width_q <= cfg_ext;
				end
			end
			if (accept) begin
				if (!sec_eff) begin
					second_q <= 1'b1;
					col_q    <= col_eff;
					odd_q    <= odd_eff;
				end else begin
					second_q <= 1'b0;
					if (last) begin
						col_q <= '0;
						odd_q <= !odd_eff;
					end else begin
						col_q <= col_eff + CW'(1);
						odd_q <= odd_eff;
					end
				end
			end
		end
	end

endmodule

### sv/bbd_back.sv
// Back end: line store of even-row pair sums, and averaging on odd rows.
module bbd_back #(
	parameter int MAX_PAIRS = 2048,
	parameter int CW        = 11,
	parameter int LW        = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_empty,
	input  bbd_pkg::cmd_t cmd,
	input  logic [CW-1:0] cmd_col,
	output logic          cmd_pop,
	input  logic [LW-1:0] res_level,
	output logic          res_push,
	output bbd_pkg::res_t res
);
	import bbd_pkg::*;

	logic [SUMS_W-1:0] line_store [MAX_PAIRS];

	logic              valid_s1;
	logic              eor_s1;
	logic [SUMS_W-1:0] sums_s1;
	logic [SUMS_W-1:0] stored_s1;
	logic              room;
	logic [LW:0]       booked;

	// A read is only started when the result queue has a slot for it.
	assign booked  = (LW + 1)'(res_level) + (LW + 1)'(valid_s1);
	assign room    = booked < (LW + 1)'(QUEUE_DEPTH);
	assign cmd_pop = !cmd_empty && (!cmd.odd_row || room);

	// Line store: even rows write, odd rows read.
	always_ff @(posedge clk) begin
		if (cmd_pop && !cmd.odd_row) begin
			line_store[cmd_col] <= cmd.sums;
		end
		if (cmd_pop && cmd.odd_row) begin
			stored_s1 <= line_store[cmd_col];
		end
	end

	// Payload of the read stage.
	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.odd_row) begin
			sums_s1 <= cmd.sums;
			eor_s1  <= cmd.end_of_row;
		end
	end

	// Valid of the read stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_pop && cmd.odd_row;
		end
	end

	// Four-pixel totals divided by four, truncating.
	always_comb begin
		logic [SUM_W:0] total;
		res.pixel      = '0;
		res.end_of_row = eor_s1;
		for (int c = 0; c < NUM_CHAN; c++) begin
			total = {1'b0, sums_s1[c*SUM_W +: SUM_W]} + {1'b0, stored_s1[c*SUM_W +: SUM_W]};
			res.pixel[c*CHAN_W +: CHAN_W] = total[SUM_W:2];
		end
	end

	assign res_push = valid_s1;

endmodule

### sv/bgra_box_downsample_2x2.sv
// Top level of the 2x2 box-filter downsampler for 8-bit BGRA pixels.
// Source pixels enter on the input queue port: a beat is taken when push is
// high and full is low, one pixel per cycle at full rate, start_of_frame set
// on the first pixel of a frame. Averaged pixels leave on the result queue
// port: while empty is low the oldest result is on pixel_out and end_of_row,
// and pop takes it. Only the second pixel of each pair on an odd source row
// yields a result; it passes through the command queue, the read stage and the
// result queue. One pixel is taken every cycle while full is low; the line
// store has one port used once per pair, so it never limits the rate.
// pairs_per_row is written through cfg_wr_en and cfg_wr_data while idle;
// zero acts as one, values above MAX_PAIRS act as MAX_PAIRS.
// Reset empties both queues, clears the row position and sets the width to
// one pair. The line store is not cleared: an odd row reads only columns the
// even row above it wrote. When the receiver stalls, results fill a four-deep
// result queue, then a four-deep command queue, after which full rises.
module bgra_box_downsample_2x2 #(
	parameter int MAX_PAIRS = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [bbd_pkg::CFG_W-1:0]   cfg_wr_data,
	input  logic                        push,
	output logic                        full,
	input  logic [bbd_pkg::PIXEL_W-1:0] pixel_in,
	input  logic                        start_of_frame,
	output logic                        empty,
	input  logic                        pop,
	output logic [bbd_pkg::PIXEL_W-1:0] pixel_out,
	output logic                        end_of_row
);
	import bbd_pkg::*;

	localparam int CW    = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int LW    = $clog2(QUEUE_DEPTH + 1);
	localparam int CMD_W = $bits(cmd_t) + CW;

	logic          cmd_push;
	logic          cmd_pop;
	logic          cmd_full;
	logic          cmd_empty;
	cmd_t          cmd_in;
	cmd_t          cmd_out;
	logic [CW-1:0] col_in;
	logic [CW-1:0] col_out;
	logic [LW-1:0] cmd_level;
	logic          res_push;
	res_t          res_in;
	res_t          res_out;
	logic          res_full;
	logic [LW-1:0] res_level;

	// Front end: position tracking and pair sums.
	bbd_front #(
		.MAX_PAIRS (MAX_PAIRS),
		.CW        (CW)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.push           (push),
		.pixel_in       (pixel_in),
		.start_of_frame (start_of_frame),
		.cmd_full       (cmd_full),
		.full           (full),
		.cmd_push       (cmd_push),
		.cmd            (cmd_in),
		.cmd_col        (col_in)
	);

	// Command queue between front and back.
	bbd_fifo #(
		.W     (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  ({cmd_in, col_in}),
		.pop    (cmd_pop),
		.rdata  ({cmd_out, col_out}),
		.full   (cmd_full),
		.empty  (cmd_empty),
		.level  (cmd_level)
	);

	// Back end: line store and averaging.
	bbd_back #(
		.MAX_PAIRS (MAX_PAIRS),
		.CW        (CW),
		.LW        (LW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty || (cmd_level == '0)),
		.cmd       (cmd_out),
		.cmd_col   (col_out),
		.cmd_pop   (cmd_pop),
		.res_level (res_level),
		.res_push  (res_push),
		.res       (res_in)
	);

	// Result queue facing the receiver.
	bbd_fifo #(
		.W     ($bits(res_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push && !res_full),
		.wdata  (res_in),
		.pop    (pop),
		.rdata  (res_out),
		.full   (res_full),
		.empty  (empty),
		.level  (res_level)
	);

	assign pixel_out  = res_out.pixel;
	assign end_of_row = res_out.end_of_row;

endmodule
